// ----- rtl/mrrs_pkg.sv -----
// Shared codes, widths and types for the motion record/replay sequencer.
// No dependencies; used by the top level and mrrs_steer (not by mrrs_frame_mem).
`default_nettype none

package mrrs_pkg;

    // Default frame store depth, in frames.
    localparam int FRAME_DEPTH_DEF = 512;

    // One stored frame: direction in [9:8], arm position in [7:0].
    localparam int ENTRY_W = 10;
    localparam int POS_W   = 8;
    localparam int DIR_W   = 2;

    // Configuration register widths and reset values.
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int DIST_W   = 12;
    localparam int THR_W    = 7;
    localparam int IVL_W    = 10;
    localparam int TIME_W   = 32;

    localparam logic [DIST_W-1:0] DANGER_RST   = 12'd200;
    localparam logic [THR_W-1:0]  THRESH_RST   = 7'd60;
    localparam logic [IVL_W-1:0]  INTERVAL_RST = 10'd30;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DANGER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;

    // Turn command / direction codes.
    localparam logic [DIR_W-1:0] DIR_STOP  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [DIR_W-1:0] CMD_NONE  = 2'd3;

    // Locked side codes.
    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_RIGHT = 2'd1;
    localparam logic [1:0] SIDE_LEFT  = 2'd2;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_RECORD = 2'd1,
        MODE_REPLAY = 2'd2
    } t_mode;

    // Result of one steering decision.
    typedef struct packed {
        logic [DIR_W-1:0] dir;
        logic [1:0]       side;
    } t_steer;

endpackage

`default_nettype wire

// ----- rtl/motion_record_replay_sequencer.sv -----
// Motion record/replay sequencer, top level.
// Depends on mrrs_pkg, mrrs_steer and mrrs_frame_mem.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready) takes one controller poll word:
//    link flag, three button levels, stick X, distance, fan flag, arm position
//    and millisecond time. Output channel (o_out_valid / i_out_ready) returns
//    exactly one result word per poll: turn command, position command with
//    its valid flag, mode and locked side.
//  - At the accept edge the poll word is captured and the frame store read
//    is launched (address from the replay index, clamped on the return
//    pass); once the read data is in and the output register is free, the
//    whole step is evaluated, the state and the frame store are updated and
//    the result is registered, which raises o_out_valid.
//  - A new poll is not taken until the last one is done, as the RAM read is
//    registered: o_in_ready drops for the evaluation cycle, which also
//    orders every store write before the next read of the same entry.
//  - A result waiting in the output register does not block acceptance; a
//    stalled receiver holds the evaluation cycle (read data stays put) until
//    the output register frees up.
//  - Reset (synchronous, active low) clears all mode, index, timing and
//    lock state and loads the register defaults; o_in_ready is low while
//    reset is held. The frame store is not cleared: replay only reads
//    frames written by the latest recording.
//  - Configuration writes (i_cfg_we, index, data) take effect at once and
//    are expected only while the block is idle.
`default_nettype none

module motion_record_replay_sequencer #(
    parameter int FRAME_DEPTH = mrrs_pkg::FRAME_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [mrrs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [mrrs_pkg::CFG_W-1:0]    i_cfg_wdata,
    // poll word
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_connected,
    input  wire logic                          i_button_l1,
    input  wire logic                          i_button_circle,
    input  wire logic                          i_button_triangle,
    input  wire logic signed [7:0]             i_stick_x,
    input  wire logic [mrrs_pkg::DIST_W-1:0]   i_distance_mm,
    input  wire logic                          i_fan_active,
    input  wire logic [mrrs_pkg::POS_W-1:0]    i_arm_position,
    input  wire logic [mrrs_pkg::TIME_W-1:0]   i_now_ms,
    // result word
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [mrrs_pkg::DIR_W-1:0]         o_turn_cmd,
    output logic                               o_position_valid,
    output logic [mrrs_pkg::POS_W-1:0]         o_position_cmd,
    output logic [1:0]                         o_mode_now,
    output logic [1:0]                         o_locked_side
);

    localparam int FCW = $clog2(FRAME_DEPTH + 1);           // frame count
    localparam int PIW = FCW + 1;                           // signed play index
    localparam int AW  = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam logic [FCW-1:0] DEPTH_C = FCW'(FRAME_DEPTH);
    localparam logic [FCW-1:0] ONE_FC  = FCW'(1);
    localparam logic signed [PIW-1:0] ONE_PI = PIW'(1);

    // configuration registers
    logic [mrrs_pkg::DIST_W-1:0] r_danger;
    logic [mrrs_pkg::THR_W-1:0]  r_thresh;
    logic [mrrs_pkg::IVL_W-1:0]  r_interval;

    // sequencer state
    logic [2:0]                   r_prev_btn,   n_prev_btn;
    mrrs_pkg::t_mode              r_mode,       n_mode;
    logic [FCW-1:0]               r_frame_cnt,  n_frame_cnt;
    logic signed [PIW-1:0]        r_play_idx,   n_play_idx;
    logic                         r_returning,  n_returning;
    logic [mrrs_pkg::POS_W-1:0]   r_start_pos,  n_start_pos;
    logic [mrrs_pkg::TIME_W-1:0]  r_last_time,  n_last_time;
    logic [1:0]                   r_side,       n_side;
    logic [mrrs_pkg::DIR_W-1:0]   r_last_dir,   n_last_dir;

    // evaluation stage: busy flag and captured poll word
    logic                         r_busy;
    logic                         r_connected;
    logic                         r_l1;
    logic                         r_circle;
    logic                         r_triangle;
    logic signed [7:0]            r_stick_x;
    logic [mrrs_pkg::DIST_W-1:0]  r_distance;
    logic                         r_fan;
    logic [mrrs_pkg::POS_W-1:0]   r_arm;
    logic [mrrs_pkg::TIME_W-1:0]  r_now;

    // output register
    logic                         r_out_valid;
    logic [mrrs_pkg::DIR_W-1:0]   r_turn,       n_turn;
    logic                         r_pos_valid,  n_pos_valid;
    logic [mrrs_pkg::POS_W-1:0]   r_pos,        n_pos;

    // frame store ports
    logic                            w_mem_we;
    logic [AW-1:0]                   w_mem_waddr;
    logic [mrrs_pkg::ENTRY_W-1:0]    w_mem_wdata;
    logic                            w_mem_re;
    logic [AW-1:0]                   w_mem_raddr;
    logic [mrrs_pkg::ENTRY_W-1:0]    w_mem_rdata;

    logic                 w_accept;
    logic                 w_done;
    logic                 w_ret_a;
    logic signed [PIW-1:0] w_fc_s;
    logic signed [PIW-1:0] w_fc_m1;
    mrrs_pkg::t_steer     w_steer;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = i_rst_n && !r_busy;
    assign w_done     = r_busy && (!r_out_valid || i_out_ready);

    assign w_fc_s  = $signed({1'b0, r_frame_cnt});
    assign w_fc_m1 = w_fc_s - ONE_PI;

    // Read address at accept: state is stable here since only one poll is
    // in flight. Return pass clamps an index past the last frame.
    assign w_ret_a  = r_returning || (i_button_triangle && !r_prev_btn[2]);
    assign w_mem_re = w_accept;
    always_comb begin
        if (w_ret_a && !r_play_idx[PIW-1] && (r_play_idx >= w_fc_s)
                && (r_frame_cnt != '0)) begin
            w_mem_raddr = AW'(r_frame_cnt - ONE_FC);
        end else begin
            w_mem_raddr = r_play_idx[AW-1:0];
        end
    end

    mrrs_frame_mem #(
        .DEPTH (FRAME_DEPTH),
        .AW    (AW),
        .DW    (mrrs_pkg::ENTRY_W)
    ) u_frame_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    mrrs_steer u_steer (
        .i_connected_unused_n (1'b1),
        .i_distance_mm        (r_distance),
        .i_fan_active         (r_fan),
        .i_stick_x            (r_stick_x),
        .i_danger             (r_danger),
        .i_thresh             (r_thresh),
        .i_side               (r_side),
        .i_last_dir           (r_last_dir),
        .o_res                (w_steer)
    );

    // Step evaluation from the captured poll, state and read data.
    always_comb begin
        logic                        l1_rise;
        logic                        l1_fall;
        logic                        ci_rise;
        logic                        tr_rise;
        logic                        ret0;
        logic [mrrs_pkg::TIME_W-1:0] lft0;
        logic [mrrs_pkg::TIME_W-1:0] elapsed;
        logic signed [PIW-1:0]       idx;
        logic [mrrs_pkg::DIR_W-1:0]  edir;

        l1_rise = r_l1 && !r_prev_btn[0];
        l1_fall = !r_l1 && r_prev_btn[0];
        ci_rise = r_circle && !r_prev_btn[1];
        tr_rise = r_triangle && !r_prev_btn[2];
        ret0    = r_returning || tr_rise;
        lft0    = tr_rise ? r_now : r_last_time;
        elapsed = r_now - lft0;
        idx     = r_play_idx;
        edir    = w_mem_rdata[mrrs_pkg::ENTRY_W-1:mrrs_pkg::POS_W];

        n_prev_btn  = r_prev_btn;
        n_mode      = r_mode;
        n_frame_cnt = r_frame_cnt;
        n_play_idx  = r_play_idx;
        n_returning = r_returning;
        n_start_pos = r_start_pos;
        n_last_time = r_last_time;
        n_side      = r_side;
        n_last_dir  = r_last_dir;
        n_turn      = mrrs_pkg::CMD_NONE;
        n_pos_valid = 1'b0;
        n_pos       = '0;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_frame_cnt[AW-1:0];
        w_mem_wdata = {w_steer.dir, r_arm};

        if (r_connected) begin
            n_prev_btn = {r_triangle, r_circle, r_l1};
            case (r_mode)
                mrrs_pkg::MODE_NORMAL: begin
                    if (l1_rise) begin
                        n_frame_cnt = '0;
                        n_play_idx  = '0;
                        n_returning = 1'b0;
                        n_start_pos = r_arm;
                        n_turn      = mrrs_pkg::DIR_STOP;
                        n_last_dir  = mrrs_pkg::DIR_STOP;
                        n_mode      = mrrs_pkg::MODE_RECORD;
                    end else if (ci_rise && (r_frame_cnt != '0)) begin
                        n_play_idx  = '0;
                        n_returning = 1'b0;
                        n_last_time = r_now;
                        n_mode      = mrrs_pkg::MODE_REPLAY;
                    end else begin
                        n_side     = w_steer.side;
                        n_turn     = w_steer.dir;
                        n_last_dir = w_steer.dir;
                    end
                end
                mrrs_pkg::MODE_RECORD: begin
                    if (l1_fall) begin
                        n_mode = mrrs_pkg::MODE_NORMAL;
                    end else begin
                        n_side     = w_steer.side;
                        n_turn     = w_steer.dir;
                        n_last_dir = w_steer.dir;
                        if (r_frame_cnt < DEPTH_C) begin
                            w_mem_we    = 1'b1;
                            n_frame_cnt = r_frame_cnt + ONE_FC;
                        end else begin
                            // store full: stop recording
                            n_mode = mrrs_pkg::MODE_NORMAL;
                        end
                    end
                end
                mrrs_pkg::MODE_REPLAY: begin
                    n_returning = ret0;
                    n_last_time = lft0;
                    if (elapsed >= {{(mrrs_pkg::TIME_W-mrrs_pkg::IVL_W){1'b0}},
                                    r_interval}) begin
                        n_last_time = r_now;
                        if (!ret0) begin
                            if (idx[PIW-1] || (idx >= w_fc_s)) begin
                                // forward end: switch to the return pass
                                n_returning = 1'b1;
                                n_play_idx  = w_fc_m1;
                            end else begin
                                n_pos_valid = 1'b1;
                                n_pos       = w_mem_rdata[mrrs_pkg::POS_W-1:0];
                                n_turn      = (edir == mrrs_pkg::CMD_NONE)
                                              ? mrrs_pkg::DIR_STOP : edir;
                                n_last_dir  = n_turn;
                                n_play_idx  = idx + ONE_PI;
                            end
                        end else if (idx[PIW-1]) begin
                            // return complete: back to the start position
                            n_turn      = mrrs_pkg::DIR_STOP;
                            n_last_dir  = mrrs_pkg::DIR_STOP;
                            n_pos_valid = 1'b1;
                            n_pos       = r_start_pos;
                            n_mode      = mrrs_pkg::MODE_NORMAL;
                        end else begin
                            if ((idx >= w_fc_s) && (r_frame_cnt != '0)) begin
                                idx = w_fc_m1;
                            end
                            n_pos_valid = 1'b1;
                            n_pos       = w_mem_rdata[mrrs_pkg::POS_W-1:0];
                            if (edir == mrrs_pkg::DIR_RIGHT) begin
                                n_turn = mrrs_pkg::DIR_LEFT;
                            end else if (edir == mrrs_pkg::DIR_LEFT) begin
                                n_turn = mrrs_pkg::DIR_RIGHT;
                            end else begin
                                n_turn = mrrs_pkg::DIR_STOP;
                            end
                            n_last_dir = n_turn;
                            n_play_idx = idx - ONE_PI;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (!w_done) begin
            w_mem_we = 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_danger   <= mrrs_pkg::DANGER_RST;
            r_thresh   <= mrrs_pkg::THRESH_RST;
            r_interval <= mrrs_pkg::INTERVAL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mrrs_pkg::CFG_DANGER:   r_danger   <= i_cfg_wdata[mrrs_pkg::DIST_W-1:0];
                mrrs_pkg::CFG_THRESH:   r_thresh   <= i_cfg_wdata[mrrs_pkg::THR_W-1:0];
                mrrs_pkg::CFG_INTERVAL: r_interval <= i_cfg_wdata[mrrs_pkg::IVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // control state and sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev_btn  <= '0;
            r_mode      <= mrrs_pkg::MODE_NORMAL;
            r_frame_cnt <= '0;
            r_play_idx  <= '0;
            r_returning <= 1'b0;
            r_start_pos <= '0;
            r_last_time <= '0;
            r_side      <= mrrs_pkg::SIDE_NONE;
            r_last_dir  <= mrrs_pkg::DIR_STOP;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end

            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_done) begin
                r_prev_btn  <= n_prev_btn;
                r_mode      <= n_mode;
                r_frame_cnt <= n_frame_cnt;
                r_play_idx  <= n_play_idx;
                r_returning <= n_returning;
                r_start_pos <= n_start_pos;
                r_last_time <= n_last_time;
                r_side      <= n_side;
                r_last_dir  <= n_last_dir;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_connected <= i_connected;
            r_l1        <= i_button_l1;
            r_circle    <= i_button_circle;
            r_triangle  <= i_button_triangle;
            r_stick_x   <= i_stick_x;
            r_distance  <= i_distance_mm;
            r_fan       <= i_fan_active;
            r_arm       <= i_arm_position;
            r_now       <= i_now_ms;
        end
        if (w_done) begin
            r_turn      <= n_turn;
            r_pos_valid <= n_pos_valid;
            r_pos       <= n_pos;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_turn_cmd       = r_turn;
    assign o_position_valid = r_pos_valid;
    assign o_position_cmd   = r_pos;
    assign o_mode_now       = r_mode;
    assign o_locked_side    = r_side;

endmodule

`default_nettype wire

// ----- rtl/mrrs_frame_mem.sv -----
// Frame store: synchronous RAM, one write port and one registered read port.
// Depends on nothing but its parameters.
`default_nettype none

module mrrs_frame_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/mrrs_steer.sv -----
// Stick steering with obstacle side lock (combinational).
// Depends on mrrs_pkg.
`default_nettype none

module mrrs_steer (
    input  wire logic                       i_connected_unused_n,
    input  wire logic [mrrs_pkg::DIST_W-1:0] i_distance_mm,
    input  wire logic                       i_fan_active,
    input  wire logic signed [7:0]          i_stick_x,
    input  wire logic [mrrs_pkg::DIST_W-1:0] i_danger,
    input  wire logic [mrrs_pkg::THR_W-1:0]  i_thresh,
    input  wire logic [1:0]                 i_side,
    input  wire logic [mrrs_pkg::DIR_W-1:0]  i_last_dir,
    output mrrs_pkg::t_steer                o_res
);

    logic [1:0]        w_side;
    logic signed [8:0] w_sx9;
    logic signed [8:0] w_pthr;
    logic signed [8:0] w_nthr;

    always_comb begin
        // Side lock: cleared when clear, else latched from the last turn if none is held.
        w_side = i_side;
        if (i_distance_mm >= i_danger) begin
            w_side = mrrs_pkg::SIDE_NONE;
        end else if (i_side == mrrs_pkg::SIDE_NONE) begin
            if (i_last_dir == mrrs_pkg::DIR_RIGHT) begin
                w_side = mrrs_pkg::SIDE_RIGHT;
            end else if (i_last_dir == mrrs_pkg::DIR_LEFT) begin
                w_side = mrrs_pkg::SIDE_LEFT;
            end
        end

        w_sx9  = {i_stick_x[7], i_stick_x};
        w_pthr = $signed({2'b00, i_thresh});
        w_nthr = -w_pthr;

        o_res.side = w_side;
        if (i_fan_active || !i_connected_unused_n) begin
            o_res.dir = mrrs_pkg::DIR_STOP;
        end else if (w_sx9 > w_pthr) begin
            o_res.dir = (w_side != mrrs_pkg::SIDE_RIGHT) ? mrrs_pkg::DIR_RIGHT
                                                          : mrrs_pkg::DIR_STOP;
        end else if (w_sx9 < w_nthr) begin
            o_res.dir = (w_side != mrrs_pkg::SIDE_LEFT) ? mrrs_pkg::DIR_LEFT
                                                         : mrrs_pkg::DIR_STOP;
        end else begin
            o_res.dir = mrrs_pkg::DIR_STOP;
        end
    end

endmodule

`default_nettype wire

// ----- test/tb_motion_record_replay_sequencer.sv -----
// Testbench for motion_record_replay_sequencer: directed polls, then random phases.
// Depends on rtl/mrrs_pkg.sv and rtl/motion_record_replay_sequencer.sv.
`timescale 1ns / 100ps

module tb_motion_record_replay_sequencer;

    localparam int DEPTH       = mrrs_pkg::FRAME_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_POLLS = 200;

    // One controller poll word.
    typedef struct {
        bit                            connected;
        bit                            l1;
        bit                            circle;
        bit                            triangle;
        bit signed [7:0]               stick;
        bit [mrrs_pkg::DIST_W-1:0]     distance;
        bit                            fan;
        bit [mrrs_pkg::POS_W-1:0]      arm;
        bit [mrrs_pkg::TIME_W-1:0]     now;
    } t_poll;

    // One result word.
    typedef struct {
        logic [mrrs_pkg::DIR_W-1:0] turn;
        logic                       pos_valid;
        logic [mrrs_pkg::POS_W-1:0] pos;
        logic [1:0]                 mode;
        logic [1:0]                 side;
    } t_word;

    // Mirror of the sequencer: its own copy of registers, mode state and frame
    // store. Each accepted poll is stepped through it and the result word it
    // should produce is queued; each result word from the block is matched
    // against the oldest queued one.
    class sequencer_mirror;
        logic [mrrs_pkg::DIST_W-1:0]  danger;
        logic [mrrs_pkg::THR_W-1:0]   thresh;
        logic [mrrs_pkg::IVL_W-1:0]   interval;

        bit                           prev_l1;
        bit                           prev_circle;
        bit                           prev_tri;
        mrrs_pkg::t_mode              mode;
        int                           count;
        int                           index;
        bit                           returning;
        logic [mrrs_pkg::POS_W-1:0]   start_pos;
        logic [mrrs_pkg::TIME_W-1:0]  last_ms;
        logic [1:0]                   blocked;
        logic [mrrs_pkg::DIR_W-1:0]   last_dir;
        logic [mrrs_pkg::ENTRY_W-1:0] frames [DEPTH];

        t_word             cur;
        t_word             pending_words [$];
        int                mismatches;

        function new();
            danger      = mrrs_pkg::DANGER_RST;
            thresh      = mrrs_pkg::THRESH_RST;
            interval    = mrrs_pkg::INTERVAL_RST;
            prev_l1     = 0;
            prev_circle = 0;
            prev_tri    = 0;
            mode        = mrrs_pkg::MODE_NORMAL;
            count       = 0;
            index       = 0;
            returning   = 0;
            start_pos   = '0;
            last_ms     = '0;
            blocked     = mrrs_pkg::SIDE_NONE;
            last_dir    = mrrs_pkg::DIR_STOP;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [mrrs_pkg::CFG_IDX_W-1:0] idx,
                              logic [mrrs_pkg::CFG_W-1:0] val);
            case (idx)
                mrrs_pkg::CFG_DANGER:   danger   = val[mrrs_pkg::DIST_W-1:0];
                mrrs_pkg::CFG_THRESH:   thresh   = val[mrrs_pkg::THR_W-1:0];
                mrrs_pkg::CFG_INTERVAL: interval = val[mrrs_pkg::IVL_W-1:0];
                default: ;
            endcase
        endfunction

        function void turn_to(logic [mrrs_pkg::DIR_W-1:0] dir);
            cur.turn = dir;
            last_dir = dir;
        endfunction

        function void move_arm(logic [mrrs_pkg::POS_W-1:0] pos);
            cur.pos_valid = 1'b1;
            cur.pos       = pos;
        endfunction

        function void steer(t_poll p);
            int sx;
            int mag;
            int thr;
            sx  = p.stick;
            mag = (sx < 0) ? -sx : sx;
            thr = thresh;
            // obstacle close: lock whichever side we were heading to; clear path releases it
            if (p.distance >= danger)
                blocked = mrrs_pkg::SIDE_NONE;
            else if (blocked == mrrs_pkg::SIDE_NONE) begin
                if (last_dir == mrrs_pkg::DIR_RIGHT)
                    blocked = mrrs_pkg::SIDE_RIGHT;
                else if (last_dir == mrrs_pkg::DIR_LEFT)
                    blocked = mrrs_pkg::SIDE_LEFT;
            end
            if (p.fan)
                turn_to(mrrs_pkg::DIR_STOP);
            else if (mag > thr) begin
                if (sx > thr)
                    turn_to(blocked != mrrs_pkg::SIDE_RIGHT ? mrrs_pkg::DIR_RIGHT
                                                            : mrrs_pkg::DIR_STOP);
                else
                    turn_to(blocked != mrrs_pkg::SIDE_LEFT ? mrrs_pkg::DIR_LEFT
                                                           : mrrs_pkg::DIR_STOP);
            end else
                turn_to(mrrs_pkg::DIR_STOP);
        endfunction

        function void replay(logic [mrrs_pkg::TIME_W-1:0] now);
            logic [mrrs_pkg::ENTRY_W-1:0] e;
            logic [mrrs_pkg::TIME_W-1:0]  elapsed;
            elapsed = now - last_ms;
            if (elapsed < mrrs_pkg::TIME_W'(interval))
                return;
            last_ms = now;
            if (!returning) begin
                // forward end: switch to the reverse pass, no command
                if (index < 0 || index >= count) begin
                    returning = 1'b1;
                    index     = count - 1;
                    return;
                end
                e = frames[index];
                move_arm(e[mrrs_pkg::POS_W-1:0]);
                turn_to(e[9:8] == mrrs_pkg::DIR_RIGHT ? mrrs_pkg::DIR_RIGHT :
                        e[9:8] == mrrs_pkg::DIR_LEFT  ? mrrs_pkg::DIR_LEFT
                                                      : mrrs_pkg::DIR_STOP);
                index++;
            end else begin
                if (index < 0) begin
                    turn_to(mrrs_pkg::DIR_STOP);
                    move_arm(start_pos);
                    mode = mrrs_pkg::MODE_NORMAL;
                    return;
                end
                // cancel past the end lands here with index == count
                if (index > count - 1 && count > 0)
                    index = count - 1;
                e = frames[index];
                move_arm(e[mrrs_pkg::POS_W-1:0]);
                turn_to(e[9:8] == mrrs_pkg::DIR_RIGHT ? mrrs_pkg::DIR_LEFT :
                        e[9:8] == mrrs_pkg::DIR_LEFT  ? mrrs_pkg::DIR_RIGHT
                                                      : mrrs_pkg::DIR_STOP);
                index--;
            end
        endfunction

        function void absorb_poll(t_poll p);
            bit l1_rise;
            bit l1_fall;
            bit ci_rise;
            bit tr_rise;
            cur.turn      = mrrs_pkg::CMD_NONE;
            cur.pos_valid = 1'b0;
            cur.pos       = '0;
            if (p.connected) begin
                l1_rise     = p.l1 && !prev_l1;
                l1_fall     = !p.l1 && prev_l1;
                ci_rise     = p.circle && !prev_circle;
                tr_rise     = p.triangle && !prev_tri;
                prev_l1     = p.l1;
                prev_circle = p.circle;
                prev_tri    = p.triangle;
                case (mode)
                    mrrs_pkg::MODE_NORMAL: begin
                        if (l1_rise) begin
                            count     = 0;
                            index     = 0;
                            returning = 1'b0;
                            start_pos = p.arm;
                            turn_to(mrrs_pkg::DIR_STOP);
                            mode = mrrs_pkg::MODE_RECORD;
                        end else if (ci_rise && count > 0) begin
                            index     = 0;
                            returning = 1'b0;
                            last_ms   = p.now;
                            mode      = mrrs_pkg::MODE_REPLAY;
                        end else
                            steer(p);
                    end
                    mrrs_pkg::MODE_RECORD: begin
                        if (l1_fall)
                            mode = mrrs_pkg::MODE_NORMAL;
                        else begin
                            steer(p);
                            if (count < DEPTH) begin
                                frames[count] = {last_dir, p.arm};
                                count++;
                            end else
                                mode = mrrs_pkg::MODE_NORMAL;   // store full
                        end
                    end
                    default: begin
                        if (tr_rise) begin
                            returning = 1'b1;
                            last_ms   = p.now;
                        end
                        replay(p.now);
                    end
                endcase
            end
            cur.mode = mode;
            cur.side = blocked;
            pending_words.push_back(cur);
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void match_result(t_word got);
            t_word want;
            if (pending_words.size() == 0) begin
                $display("%0t: result word with none expected: turn %0d pos %0d/%0d",
                         $time, got.turn, got.pos_valid, got.pos);
                mismatches++;
                return;
            end
            want = pending_words.pop_front();
            check_field("turn_cmd", 8'(want.turn), 8'(got.turn));
            check_field("position_valid", 8'(want.pos_valid), 8'(got.pos_valid));
            check_field("position_cmd", want.pos, got.pos);
            check_field("mode_now", 8'(want.mode), 8'(got.mode));
            check_field("locked_side", 8'(want.side), 8'(got.side));
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [mrrs_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [mrrs_pkg::CFG_W-1:0]      i_cfg_wdata;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic                            i_connected;
    logic                            i_button_l1;
    logic                            i_button_circle;
    logic                            i_button_triangle;
    logic signed [7:0]               i_stick_x;
    logic [mrrs_pkg::DIST_W-1:0]     i_distance_mm;
    logic                            i_fan_active;
    logic [mrrs_pkg::POS_W-1:0]      i_arm_position;
    logic [mrrs_pkg::TIME_W-1:0]     i_now_ms;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [mrrs_pkg::DIR_W-1:0]      o_turn_cmd;
    logic                            o_position_valid;
    logic [mrrs_pkg::POS_W-1:0]      o_position_cmd;
    logic [1:0]                      o_mode_now;
    logic [1:0]                      o_locked_side;

    sequencer_mirror mirror;

    int          send_gap_pct;   // chance per cycle that the poll side holds off
    int          recv_stall_pct; // chance per cycle that the result side stalls
    int          cycles;
    int          take_left;      // polls left to hold L1 in the current take
    bit          long_take;      // current take is meant to overflow the store
    bit          long_due;       // next take should be the overflowing one
    bit [31:0]   wall_ms;        // millisecond clock fed to the block

    motion_record_replay_sequencer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_connected      (i_connected),
        .i_button_l1      (i_button_l1),
        .i_button_circle  (i_button_circle),
        .i_button_triangle(i_button_triangle),
        .i_stick_x        (i_stick_x),
        .i_distance_mm    (i_distance_mm),
        .i_fan_active     (i_fan_active),
        .i_arm_position   (i_arm_position),
        .i_now_ms         (i_now_ms),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_turn_cmd       (o_turn_cmd),
        .o_position_valid (o_position_valid),
        .o_position_cmd   (o_position_cmd),
        .o_mode_now       (o_mode_now),
        .o_locked_side    (o_locked_side)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: ready is redrawn every falling edge.
    initial begin
        forever begin
            @(negedge i_clk);
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Every result word taken at a rising edge is matched right there.
    always @(posedge i_clk) begin
        t_word got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.turn      = o_turn_cmd;
            got.pos_valid = o_position_valid;
            got.pos       = o_position_cmd;
            got.mode      = o_mode_now;
            got.side      = o_locked_side;
            mirror.match_result(got);
        end
    end

    function automatic t_poll mk(bit c, bit l1, bit ci, bit tr, int sx, int dist_mm,
                                 bit fan, int arm, bit [31:0] now);
        t_poll p;
        p.connected = c;
        p.l1        = l1;
        p.circle    = ci;
        p.triangle  = tr;
        p.stick     = sx[7:0];
        p.distance  = dist_mm[mrrs_pkg::DIST_W-1:0];
        p.fan       = fan;
        p.arm       = arm[mrrs_pkg::POS_W-1:0];
        p.now       = now;
        return p;
    endfunction

    // Starts and ends on a falling edge. Valid goes up once the hold-off is
    // over and stays up until the word is taken.
    task automatic send_poll(input t_poll p);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_connected       <= p.connected;
        i_button_l1       <= p.l1;
        i_button_circle   <= p.circle;
        i_button_triangle <= p.triangle;
        i_stick_x         <= p.stick;
        i_distance_mm     <= p.distance;
        i_fan_active      <= p.fan;
        i_arm_position    <= p.arm;
        i_now_ms          <= p.now;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        mirror.absorb_poll(p);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        while (mirror.pending_words.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_regs(input int danger, input int thr, input int ivl);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= mrrs_pkg::CFG_DANGER;
        i_cfg_wdata <= mrrs_pkg::CFG_W'(danger);
        @(negedge i_clk);
        mirror.set_reg(mrrs_pkg::CFG_DANGER, mrrs_pkg::CFG_W'(danger));
        i_cfg_idx   <= mrrs_pkg::CFG_THRESH;
        i_cfg_wdata <= mrrs_pkg::CFG_W'(thr);
        @(negedge i_clk);
        mirror.set_reg(mrrs_pkg::CFG_THRESH, mrrs_pkg::CFG_W'(thr));
        i_cfg_idx   <= mrrs_pkg::CFG_INTERVAL;
        i_cfg_wdata <= mrrs_pkg::CFG_W'(ivl);
        @(negedge i_clk);
        mirror.set_reg(mrrs_pkg::CFG_INTERVAL, mrrs_pkg::CFG_W'(ivl));
        i_cfg_we    <= 1'b0;
    endtask

    // Next random poll. Reads the mirror's state so that most words form
    // proper takes and replays; the rest is noise and broken sequences.
    function automatic t_poll plan_poll();
        t_poll       p;
        int          thr;
        int          dg;
        int          sx;
        int          d;
        int          pick;
        int unsigned iv;
        bit [31:0]   dt;

        thr = mirror.thresh;
        dg  = mirror.danger;
        iv  = mirror.interval;

        // stick and distance lean on the threshold and danger edges
        case ($urandom_range(0, 5))
            0:       sx = thr + 1;
            1:       sx = thr;
            2:       sx = -thr - 1;
            3:       sx = -thr;
            4:       sx = $urandom_range(0, 1) ? 127 : -128;
            default: sx = int'($urandom_range(0, 255)) - 128;
        endcase
        if (sx > 127)  sx = 127;
        if (sx < -128) sx = -128;
        case ($urandom_range(0, 5))
            0:       d = dg - 1;
            1:       d = dg;
            2:       d = dg + 1;
            3:       d = 0;
            4:       d = 4095;
            default: d = $urandom_range(0, 4095);
        endcase
        if (d < 0)    d = 0;
        if (d > 4095) d = 4095;

        // time step: mostly around the replay interval, sometimes a wild jump
        case ($urandom_range(0, 19))
            0:             dt = $urandom();
            1, 2:          dt = $urandom_range(0, 3);
            3, 4, 5, 6, 7: dt = (iv == 0) ? 0 : $urandom_range(0, iv - 1);
            default:       dt = iv + $urandom_range(0, iv);
        endcase
        wall_ms += dt;

        p.connected = 1'b1;
        p.l1        = 1'b0;
        p.circle    = 1'b0;
        p.triangle  = 1'b0;
        p.stick     = sx[7:0];
        p.distance  = d[mrrs_pkg::DIST_W-1:0];
        p.fan       = ($urandom_range(0, 99) < 15);
        case ($urandom_range(0, 9))
            0:       p.arm = 0;
            1:       p.arm = 180;
            default: p.arm = $urandom_range(0, 180);
        endcase
        p.now = wall_ms;

        // link down: buttons at random, nothing should move
        if ($urandom_range(0, 99) < 4) begin
            p.connected = 1'b0;
            p.l1        = $urandom_range(0, 1);
            p.circle    = $urandom_range(0, 1);
            p.triangle  = $urandom_range(0, 1);
            return p;
        end

        case (mirror.mode)
            mrrs_pkg::MODE_NORMAL: begin
                long_take = 1'b0;
                pick = $urandom_range(0, 99);
                if ((pick < 12 || long_due) && !mirror.prev_l1)
                    p.l1 = 1'b1;
                else if (pick < 30 && mirror.count > 0)
                    p.circle = !mirror.prev_circle;
                else begin
                    p.l1       = ($urandom_range(0, 19) == 0);
                    p.circle   = ($urandom_range(0, 19) == 0);
                    p.triangle = $urandom_range(0, 1);
                end
                // L1 rise opens a take: decide how long it is held
                if (p.l1 && !mirror.prev_l1) begin
                    if (long_due) begin
                        long_due  = 1'b0;
                        long_take = 1'b1;
                        take_left = DEPTH + 20;
                    end else
                        take_left = $urandom_range(0, 20);
                end
            end
            mrrs_pkg::MODE_RECORD: begin
                p.circle   = $urandom_range(0, 1);
                p.triangle = $urandom_range(0, 1);
                if (take_left > 0) begin
                    take_left--;
                    p.l1 = long_take || ($urandom_range(0, 19) != 0);
                end
            end
            default: begin
                p.l1     = $urandom_range(0, 1);
                p.circle = $urandom_range(0, 1);
                // cancel: often right at the forward end, now and then earlier
                if (!mirror.prev_tri) begin
                    if (!mirror.returning && mirror.index == mirror.count)
                        p.triangle = $urandom_range(0, 1);
                    else if (!mirror.returning)
                        p.triangle = ($urandom_range(0, 99) < 8);
                    else
                        p.triangle = ($urandom_range(0, 99) < 3);
                end
            end
        endcase
        return p;
    endfunction

    initial begin
        int sent;
        t_poll p;

        cycles            = 0;
        send_gap_pct      = 0;
        recv_stall_pct    = 0;
        take_left         = 0;
        long_take         = 1'b0;
        long_due          = 1'b0;
        wall_ms           = '0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_wdata       = '0;
        i_in_valid        = 1'b0;
        i_connected       = 1'b0;
        i_button_l1       = 1'b0;
        i_button_circle   = 1'b0;
        i_button_triangle = 1'b0;
        i_stick_x         = '0;
        i_distance_mm     = '0;
        i_fan_active      = 1'b0;
        i_arm_position    = '0;
        i_now_ms          = '0;
        i_out_ready       = 1'b0;
        mirror = new();

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words under the reset register values
        // (danger 200, threshold 60, interval 30).
        // link down with every button pressed and extreme field values: must change nothing
        send_poll(mk(0, 1, 1, 1, -128, 4095, 1, 180, 32'hFFFF_FFFF));
        // circle with no frames stored is ignored, steering goes on
        send_poll(mk(1, 0, 1, 0, 127, 4095, 0, 0, 0));
        // obstacle while turning right locks the right side
        send_poll(mk(1, 0, 0, 0, 127, 0, 0, 0, 1));
        send_poll(mk(1, 0, 0, 0, -128, 0, 0, 0, 2));
        // clear distance releases the lock; threshold edges both ways
        send_poll(mk(1, 0, 0, 0, 61, 4095, 0, 0, 3));
        send_poll(mk(1, 0, 0, 0, 60, 4095, 0, 0, 4));
        send_poll(mk(1, 0, 0, 0, -61, 4095, 0, 0, 5));
        send_poll(mk(1, 0, 0, 0, -60, 4095, 0, 0, 6));
        send_poll(mk(1, 0, 0, 0, 127, 4095, 1, 0, 7));
        // short take: start at 90, two frames, release
        send_poll(mk(1, 1, 0, 0, 0, 4095, 0, 90, 8));
        send_poll(mk(1, 1, 0, 0, 127, 4095, 0, 180, 9));
        send_poll(mk(1, 1, 0, 0, -128, 4095, 0, 0, 10));
        send_poll(mk(1, 0, 0, 0, 0, 4095, 0, 45, 11));
        // replay: too early, two forward frames, cancel past the end,
        // two reversed frames, then back to the start position
        send_poll(mk(1, 0, 1, 0, 0, 4095, 0, 0, 1000));
        send_poll(mk(1, 0, 0, 0, 0, 4095, 0, 0, 1010));
        send_poll(mk(1, 0, 0, 0, 0, 4095, 0, 0, 1030));
        send_poll(mk(1, 0, 0, 0, 0, 4095, 0, 0, 1060));
        send_poll(mk(1, 0, 0, 1, 0, 4095, 0, 0, 1070));
        send_poll(mk(1, 0, 0, 0, 0, 4095, 0, 0, 1100));
        send_poll(mk(1, 0, 0, 0, 0, 4095, 0, 0, 1130));
        send_poll(mk(1, 0, 0, 0, 0, 4095, 0, 0, 1160));
        i_in_valid <= 1'b0;

        wall_ms = $urandom();
        for (int ph = 0; ph < 8; ph++) begin
            drain_results();
            case (ph)
                0:       load_regs(4095, 127, 1000);
                1:       load_regs(0, 0, 1);
                2:       load_regs(200, 60, 0);     // every poll advances a replay
                default: load_regs($urandom_range(0, 4095), $urandom_range(0, 127),
                                   $urandom_range(1, 1000));
            endcase
            case (ph % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 88; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 88; end
                default: begin send_gap_pct = 32; recv_stall_pct = 32; end
            endcase
            // one take long enough to fill the frame store
            if (ph == 4)
                long_due = 1'b1;
            sent = 0;
            while (sent < PHASE_POLLS) begin
                p = plan_poll();
                send_poll(p);
                if (p.connected)
                    sent++;
            end
            i_in_valid <= 1'b0;
        end

        drain_results();
        if (mirror.mismatches == 0 && mirror.pending_words.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
